@@ design/smc_pkg.sv @@
// shared types, constants and helpers for the sentence pattern match counter
package smc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int SENT_W      = 16;
    localparam int TOTAL_W     = 32;
    localparam int FILES_W     = 16;
    localparam int OUT_DATA_W  = 72;

    localparam logic [7:0] CH_STOP    = 8'h2E;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic {
        KIND_TEXT = 1'b0,
        KIND_EOF  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2
    } t_cfg_idx;

    // one input beat as it leaves the input register
    typedef struct packed {
        logic       step;
        t_kind      kind;
        logic [7:0] data;
    } t_beat;

    // one result as it enters the output register
    typedef struct packed {
        logic               valid;
        logic [SENT_W-1:0]  sentence_matches;
        logic               sentence_hit;
        logic [TOTAL_W-1:0] total_matches;
        logic               file_done;
        logic               file_hit;
        logic [FILES_W-1:0] files_with_hits;
    } t_result;

    function automatic logic is_delim(input logic [7:0] b);
        is_delim = (b == CH_STOP) || (b == CH_QUERY) || (b == CH_BANG) || (b == CH_NEWLINE);
    endfunction

    // clamp the programmed length into 1..MAX_PATTERN
    function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) n = LEN_W'(1);
        if (n > LEN_W'(MAX_PATTERN)) n = LEN_W'(MAX_PATTERN);
        used_len = n;
    endfunction

endpackage

@@ design/smc_window.sv @@
// byte window of the current sentence and the parallel pattern compare
module smc_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  smc_pkg::t_beat            i_beat,
    input  logic [smc_pkg::PAT_W-1:0] i_pattern,
    input  logic [smc_pkg::LEN_W-1:0] i_pat_len,
    output logic                      o_match
);
    import smc_pkg::*;

    logic [7:0]       r_win [MAX_PATTERN];
    logic [LEN_W-1:0] r_fill;
    logic             r_nul;

    logic [7:0]       n_win [MAX_PATTERN];
    logic [LEN_W-1:0] n_fill;
    logic [LEN_W-1:0] len_n;
    logic             is_text;
    logic             push;
    logic [MAX_PATTERN-1:0] eq;
    logic [LEN_W-1:0] pos [MAX_PATTERN];

    // classify the beat
    assign is_text = (i_beat.kind == KIND_TEXT) && !is_delim(i_beat.data);
    assign push    = is_text && !r_nul && (i_beat.data != CH_NUL);
    assign len_n   = used_len(i_pat_len);

    // window after the shift
    always_comb begin
        n_win[0] = i_beat.data;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_fill = (r_fill < LEN_W'(MAX_PATTERN)) ? r_fill + LEN_W'(1) : r_fill;
    end

    // pattern byte k lines up with window slot n-1-k
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pos[k] = len_n - LEN_W'(1) - LEN_W'(k);
            eq[k]  = (LEN_W'(k) >= len_n) ||
                     (n_win[pos[k][IDX_W-1:0]] == i_pattern[8*k +: 8]);
        end
    end

    assign o_match = i_beat.step && push && (n_fill >= len_n) && (&eq);

    // window bytes hold no reset, the fill count gates them
    always_ff @(posedge i_clk) begin
        if (i_beat.step && push) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= n_win[j];
            end
        end
    end

    // fill count and nul flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_nul  <= 1'b0;
        end else if (i_beat.step) begin
            if (!is_text) begin
                r_fill <= '0;
                r_nul  <= 1'b0;
            end else begin
                if (i_beat.data == CH_NUL) r_nul <= 1'b1;
                if (push) r_fill <= n_fill;
            end
        end
    end

endmodule

@@ design/smc_count.sv @@
// sentence, file and running totals, and result assembly
module smc_count (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smc_pkg::t_beat   i_beat,
    input  logic             i_match,
    output smc_pkg::t_result o_result
);
    import smc_pkg::*;

    logic [SENT_W-1:0]  r_sent;
    logic [TOTAL_W-1:0] r_total;
    logic [FILES_W-1:0] r_files;
    logic               r_file_matched;

    logic [FILES_W-1:0] n_files;
    logic               close;
    logic               is_eof;
    logic               hit;
    logic               fhit;

    assign is_eof = (i_beat.kind == KIND_EOF);
    assign close  = i_beat.step && (is_eof || is_delim(i_beat.data));
    assign hit    = (r_sent != '0);
    assign fhit   = is_eof && (r_file_matched || hit);

    // file total after this beat
    always_comb begin
        n_files = r_files;
        if (fhit && (r_files != '1)) n_files = r_files + FILES_W'(1);
    end

    // result of a closing beat
    always_comb begin
        o_result.valid            = close;
        o_result.sentence_matches = r_sent;
        o_result.sentence_hit     = hit;
        o_result.total_matches    = r_total;
        o_result.file_done        = is_eof;
        o_result.file_hit         = fhit;
        o_result.files_with_hits  = n_files;
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent         <= '0;
            r_total        <= '0;
            r_files        <= '0;
            r_file_matched <= 1'b0;
        end else if (close) begin
            r_sent  <= '0;
            r_files <= n_files;
            if (is_eof) r_file_matched <= 1'b0;
            else if (hit) r_file_matched <= 1'b1;
        end else if (i_match) begin
            if (r_sent != '1) r_sent <= r_sent + SENT_W'(1);
            if (r_total != '1) r_total <= r_total + TOTAL_W'(1);
        end
    end

endmodule

@@ design/sentence_pattern_match_counter.sv @@
// top level: input register, window compare, counters and output register
// a closing beat passes from the input register into the output register, and waits while that is full
// throughput: one beat per cycle while the output register can take results, set by the 16-byte window compare
// a text byte that does not close a sentence produces no output beat
// reset (synchronous, active low) clears counters, window fill, pattern to zero, length to one
module sentence_pattern_match_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // data_byte[7:0]
    input  logic                           i_s_tuser,  // kind[0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // sentence_matches[15:0], sentence_hit[16], total_matches[48:17],
    // file_hit[49], files_with_hits[65:50], zero pad[71:66]
    output logic [smc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tuser,  // file_done[0]
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import smc_pkg::*;

    logic [63:0]      r_pat_lo;
    logic [63:0]      r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;

    logic             r_in_valid;
    t_kind            r_in_kind;
    logic [7:0]       r_in_data;

    logic             r_out_valid;
    t_result          r_out;

    t_beat            beat;
    t_result          res;
    logic             match;
    logic             out_free;
    logic             advance;
    logic             in_close;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free   = !r_out_valid || i_m_tready;
    assign in_close   = (r_in_kind == KIND_EOF) || is_delim(r_in_data);
    assign advance    = r_in_valid && (!in_close || out_free);
    assign o_s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= t_kind'(i_s_tuser);
            r_in_data <= i_s_tdata;
        end
    end

    assign beat.step = advance;
    assign beat.kind = r_in_kind;
    assign beat.data = r_in_data;

    smc_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_pattern ({r_pat_hi, r_pat_lo}),
        .i_pat_len (r_pat_len),
        .o_match   (match)
    );

    smc_count u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .i_match  (match),
        .o_result (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.valid) r_out <= res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.file_done;
    assign o_m_tdata  = {6'b0, r_out.files_with_hits, r_out.file_hit, r_out.total_matches,
                         r_out.sentence_hit, r_out.sentence_matches};

    // a closing beat never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.valid && r_out_valid && !i_m_tready))
        else $error("result register overwritten");

    // an accepted beat is held in the input register on the next cycle
    a_in_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_in_valid)
        else $error("accepted beat lost");

    // the sentence hit flag agrees with the sentence count
    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16] == (o_m_tdata[15:0] != '0)))
        else $error("sentence hit flag mismatch");

    // a file hit is only reported when the file closes
    a_file_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> !o_m_tdata[49])
        else $error("file hit without file close");

endmodule

@@ test/sentence_pattern_match_counter_tb.sv @@
// self-checking testbench for the sentence pattern match counter
`timescale 1ns / 1ps

module sentence_pattern_match_counter_tb;
    import smc_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 62;
    localparam int DIR_ROWS      = 27;

    // one sentence report as it leaves the block
    typedef struct packed {
        logic [15:0] sentence_matches;
        logic        sentence_hit;
        logic [31:0] total_matches;
        logic        file_done;
        logic        file_hit;
        logic [15:0] files_with_hits;
    } t_sentence_report;

    // one line of the directed script: a register write or a text beat
    typedef struct packed {
        logic             is_cfg;
        t_cfg_idx         cfg_idx;
        logic [63:0]      cfg_val;
        t_kind            kind;
        logic [7:0]       data;
        logic             typed;
        t_sentence_report want;
    } t_script_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;

    // typed expectation travelling alongside the beat being offered
    logic             beat_typed = 1'b0;
    t_sentence_report beat_want  = '0;

    // idling percentages for sender and receiver
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // mirror of the block: configuration
    logic [63:0] mirror_pat_lo  = '0;
    logic [63:0] mirror_pat_hi  = '0;
    logic [4:0]  mirror_pat_len = 5'd1;

    // mirror of the block: sentence and file state
    logic [7:0]  text_window [16];
    int          window_fill    = 0;
    logic        nul_hidden     = 1'b0;
    logic [15:0] sentence_hits  = '0;
    logic        file_had_hit   = 1'b0;
    logic [31:0] match_total    = '0;
    logic [15:0] files_hit      = '0;

    // pattern as the stimulus sees it
    logic [127:0] stim_pattern = '0;
    int           stim_len     = 1;

    t_sentence_report sentence_reports_due[$];

    int errors        = 0;
    int quiet_cycles  = 0;
    int beats_in      = 0;
    int reports_seen  = 0;
    int hit_sentences = 0;
    int file_closes   = 0;
    int peak_sentence = 0;
    int peak_files    = 0;

    sentence_pattern_match_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // directed script: reset values, overlap, nul hiding, length clamps, extremes
    t_script_row directed_script [DIR_ROWS] = '{
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_EOF, 8'h00, 1'b1,
          '{16'd0, 1'b0, 32'd0, 1'b1, 1'b0, 16'd0}},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_NUL, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_NUL, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_STOP, 1'b1,
          '{16'd0, 1'b0, 32'd0, 1'b0, 1'b0, 16'd0}},
        '{1'b1, CFG_PAT_LO, 64'h6161, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b1, CFG_PAT_HI, 64'd0, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b1, CFG_PAT_LEN, 64'd2, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_QUERY, 1'b1,
          '{16'd3, 1'b1, 32'd3, 1'b0, 1'b0, 16'd0}},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_NUL, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_NEWLINE, 1'b1,
          '{16'd0, 1'b0, 32'd3, 1'b0, 1'b0, 16'd0}},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_EOF, 8'h00, 1'b1,
          '{16'd0, 1'b0, 32'd3, 1'b1, 1'b1, 16'd1}},
        '{1'b1, CFG_PAT_LEN, 64'd0, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'h61, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, CH_BANG, 1'b1,
          '{16'd1, 1'b1, 32'd4, 1'b0, 1'b0, 16'd1}},
        '{1'b1, CFG_PAT_LO, '1, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b1, CFG_PAT_HI, '1, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b1, CFG_PAT_LEN, 64'd16, KIND_TEXT, 8'h00, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_EOF, 8'h00, 1'b1,
          '{16'd0, 1'b0, 32'd4, 1'b1, 1'b1, 16'd2}},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_TEXT, 8'hFF, 1'b0, '0},
        '{1'b0, CFG_PAT_LO, 64'd0, KIND_EOF, CH_STOP, 1'b1,
          '{16'd0, 1'b0, 32'd4, 1'b1, 1'b0, 16'd2}}
    };

    // programmed length folded into 1..16
    function automatic int clamp_len(input logic [4:0] len);
        int n;
        n = len;
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    // advance the mirrored state by one beat; returns 1 when a report is due
    function automatic bit count_text_beat(input t_kind kind, input logic [7:0] data,
                                           output t_sentence_report rep);
        logic [127:0] pat;
        logic         closes;
        logic         same;
        int           n;
        pat    = {mirror_pat_hi, mirror_pat_lo};
        closes = (data == CH_STOP) || (data == CH_QUERY) ||
                 (data == CH_BANG) || (data == CH_NEWLINE);
        n      = clamp_len(mirror_pat_len);
        rep    = '0;
        if (kind == KIND_TEXT && !closes) begin
            if (data == CH_NUL) nul_hidden = 1'b1;
            if (!nul_hidden) begin
                for (int i = 15; i > 0; i--) text_window[i] = text_window[i-1];
                text_window[0] = data;
                if (window_fill < MAX_PATTERN) window_fill++;
                if (window_fill >= n) begin
                    same = 1'b1;
                    // oldest of the newest n bytes in the window lines up with pattern byte 0
                    for (int i = 0; i < n; i++) begin
                        if (text_window[n-1-i] != pat[8*i +: 8]) same = 1'b0;
                    end
                    if (same) begin
                        if (sentence_hits != 16'hFFFF) sentence_hits++;
                        if (match_total != 32'hFFFF_FFFF) match_total++;
                    end
                end
            end
            return 1'b0;
        end
        rep.sentence_matches = sentence_hits;
        rep.sentence_hit     = (sentence_hits != 0);
        if (rep.sentence_hit) file_had_hit = 1'b1;
        if (kind == KIND_EOF) begin
            rep.file_hit = file_had_hit;
            if (file_had_hit && files_hit != 16'hFFFF) files_hit++;
            file_had_hit = 1'b0;
        end
        rep.total_matches   = match_total;
        rep.file_done       = (kind == KIND_EOF);
        rep.files_with_hits = files_hit;
        for (int i = 0; i < 16; i++) text_window[i] = '0;
        window_fill   = 0;
        nul_hidden    = 1'b0;
        sentence_hits = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    initial begin
        for (int i = 0; i < 16; i++) text_window[i] = '0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // register writes update the mirrored configuration
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LO:  mirror_pat_lo  = i_cfg_data;
                CFG_PAT_HI:  mirror_pat_hi  = i_cfg_data;
                CFG_PAT_LEN: mirror_pat_len = i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // accepted input beats feed the mirror
    always @(posedge i_clk) begin
        t_sentence_report rep;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            beats_in++;
            if (count_text_beat(t_kind'(i_s_tuser), i_s_tdata, rep))
                sentence_reports_due.push_back(beat_typed ? beat_want : rep);
        end
    end

    // accepted output beats against the oldest report due
    always @(posedge i_clk) begin
        t_sentence_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            reports_seen++;
            if (sentence_reports_due.size() == 0) begin
                $display("%0t: unexpected report, expected none, got tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = sentence_reports_due.pop_front();
                check_field("sentence_matches", want.sentence_matches, o_m_tdata[15:0]);
                check_field("sentence_hit", want.sentence_hit, o_m_tdata[16]);
                check_field("total_matches", want.total_matches, o_m_tdata[48:17]);
                check_field("file_done", want.file_done, o_m_tuser);
                check_field("file_hit", want.file_hit, o_m_tdata[49]);
                check_field("files_with_hits", want.files_with_hits, o_m_tdata[65:50]);
            end
            if (o_m_tdata[16]) hit_sentences++;
            if (o_m_tuser) file_closes++;
            if (int'(o_m_tdata[15:0]) > peak_sentence) peak_sentence = int'(o_m_tdata[15:0]);
            if (int'(o_m_tdata[65:50]) > peak_files) peak_files = int'(o_m_tdata[65:50]);
        end
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d reports outstanding",
                     $time, quiet_cycles, sentence_reports_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // offer one beat, with random idle cycles before it
    task automatic send_beat(input t_kind kind, input logic [7:0] data,
                             input logic typed, input t_sentence_report want);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= data;
        beat_typed <= typed;
        beat_want  <= want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hold off the sender until every report has come, plus pipeline slack
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sentence_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller drops valid after the last of a group
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_pattern(input logic [127:0] pat, input logic [4:0] len);
        write_reg(CFG_PAT_LO, pat[63:0]);
        write_reg(CFG_PAT_HI, pat[127:64]);
        write_reg(CFG_PAT_LEN, {59'd0, len});
        i_cfg_valid  <= 1'b0;
        stim_pattern  = pat;
        stim_len      = clamp_len(len);
    endtask

    // stimulus
    initial begin
        logic [4:0]   phase_lens [PHASES];
        logic [127:0] pat;
        logic [7:0]   mark;
        int           items;
        int           pick;
        logic         paused;

        phase_lens = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd3,
                       5'd17, 5'd16, 5'd5, 5'd1, 5'd8, 5'd4};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script
        tx_idle_pct  = 23;
        rx_idle_pct <= 47;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed_script[r].is_cfg) begin
                if (r == 0 || !directed_script[r-1].is_cfg) settle();
                write_reg(directed_script[r].cfg_idx, directed_script[r].cfg_val);
                if (r == DIR_ROWS - 1 || !directed_script[r+1].is_cfg) i_cfg_valid <= 1'b0;
            end else begin
                send_beat(directed_script[r].kind, directed_script[r].data,
                          directed_script[r].typed, directed_script[r].want);
            end
        end

        // random phases, each with a fresh pattern; sentences run across changes
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph / 4)
                0: begin tx_idle_pct = 23; rx_idle_pct <= 47; end
                1: begin tx_idle_pct = 47; rx_idle_pct <= 23; end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            for (int i = 0; i < 16; i++)
                pat[8*i +: 8] = ($urandom_range(99, 0) < 85) ?
                                8'h61 + 8'($urandom_range(1, 0)) :
                                8'($urandom_range(255, 0));
            program_pattern(pat, phase_lens[ph]);
            items  = 0;
            paused = 1'b0;
            while (items < PHASE_ITEMS) begin
                if (!paused && items >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
                pick = $urandom_range(99, 0);
                if (pick < 3) begin
                    send_beat(KIND_EOF, 8'($urandom_range(255, 0)), 1'b0, '0);
                    items++;
                end else if (pick < 12) begin
                    case ($urandom_range(3, 0))
                        0: mark = CH_STOP;
                        1: mark = CH_QUERY;
                        2: mark = CH_BANG;
                        default: mark = CH_NEWLINE;
                    endcase
                    send_beat(KIND_TEXT, mark, 1'b0, '0);
                    items++;
                end else if (pick < 14) begin
                    send_beat(KIND_TEXT, CH_NUL, 1'b0, '0);
                    items++;
                end else if (pick < 26) begin
                    send_beat(KIND_TEXT, 8'($urandom_range(255, 0)), 1'b0, '0);
                    items++;
                end else if (pick < 40) begin
                    // whole pattern, so that long patterns still match
                    for (int i = 0; i < stim_len; i++)
                        send_beat(KIND_TEXT, stim_pattern[8*i +: 8], 1'b0, '0);
                    items += stim_len;
                end else begin
                    pick = $urandom_range(stim_len - 1, 0);
                    send_beat(KIND_TEXT, stim_pattern[8*pick +: 8], 1'b0, '0);
                    items++;
                end
            end
        end

        settle();
        $display("%0d input beats, %0d reports (%0d sentences with a hit, %0d file closes)",
                 beats_in, reports_seen, hit_sentences, file_closes);
        $display("peak sentence count %0d, peak files with hits %0d, %0d mismatches",
                 peak_sentence, peak_files, errors);
        if (errors == 0 && sentence_reports_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
